// ----- hdl/i2cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared types, command codes and helpers for the bit-banged I2C master.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START1    = 4'd1,
		PH_ADDR1     = 4'd2,
		PH_REG       = 4'd3,
		PH_START2    = 4'd4,
		PH_ADDR2     = 4'd5,
		PH_WRITE     = 4'd6,
		PH_READ      = 4'd7,
		PH_STOP      = 4'd8,
		PH_STOP_NACK = 4'd9
	} phase_t;

	localparam logic [2:0] CMD_READ      = 3'd1;
	localparam logic [2:0] CMD_WRITE     = 3'd2;
	localparam logic [2:0] CMD_REG_READ  = 3'd3;
	localparam logic [2:0] CMD_REG_WRITE = 3'd4;

	// slot markers within one byte
	localparam logic [4:0] SLOT_BITS_END = 5'd24;
	localparam logic [4:0] SLOT_ACK_SCL  = 5'd25;
	localparam logic [4:0] SLOT_ACK_SMP  = 5'd26;

	typedef struct packed {
		logic [2:0] func;
		logic [6:0] target_addr;
		logic [7:0] reg_addr;
		logic [7:0] length;
		logic [7:0] tx_data;
		logic       sda_level;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [7:0] rx_data;
		logic       rx_valid;
		logic       tx_taken;
		logic       done_res;
		logic       status;
		logic       busy_res;
	} result_t;

	typedef struct packed {
		logic [2:0] bit_idx;
		logic [1:0] sub;
	} bitpos_t;

	// split a bit-phase slot (0..23) into bit number and sub-slot: s/3 by s*11>>5
	function automatic bitpos_t slot_split(input logic [4:0] s);
		logic [8:0] prod;
		bitpos_t    p;
		prod      = 9'(s) * 9'd11;
		p.bit_idx = prod[7:5];
		p.sub     = 2'(s - ({2'b00, p.bit_idx} + {1'b0, p.bit_idx, 1'b0}));
		return p;
	endfunction

endpackage

// ----- hdl/i2cbb_seq.sv -----
// ----------------------------------------------------------------------------
// i2cbb_seq
// Bus sequencer state and the single-slot step logic.
// ----------------------------------------------------------------------------
module i2cbb_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  i2cbb_pkg::item_t    item,
	output i2cbb_pkg::result_t  res
);

	i2cbb_pkg::phase_t phase_q, ph, nxt;
	logic [4:0] slot_q, s;
	logic [7:0] shift_q, sb;
	logic [7:0] bytes_q, bl;
	logic [2:0] cmd_q, cmd;
	logic [6:0] addr_q, addr;
	logic [7:0] reg_q, rg;
	logic       ack_q, ack;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic       last;
	i2cbb_pkg::bitpos_t wpos, rpos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cbb_pkg::PH_IDLE;
			slot_q  <= '0;
			shift_q <= '0;
			bytes_q <= '0;
			cmd_q   <= '0;
			addr_q  <= '0;
			reg_q   <= '0;
			ack_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (step_en) begin
			phase_q <= ph;
			slot_q  <= s;
			shift_q <= sb;
			bytes_q <= bl;
			cmd_q   <= cmd;
			addr_q  <= addr;
			reg_q   <= rg;
			ack_q   <= ack;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
		end
	end

	always_comb begin
		ph    = phase_q;
		s     = slot_q;
		sb    = shift_q;
		bl    = bytes_q;
		cmd   = cmd_q;
		addr  = addr_q;
		rg    = reg_q;
		ack   = ack_q;
		scl_n = scl_q;
		sda_n = sda_q;
		last  = 1'b0;
		nxt   = i2cbb_pkg::PH_IDLE;
		res   = '0;

		// command taken only when idle
		if (ph == i2cbb_pkg::PH_IDLE && item.func >= i2cbb_pkg::CMD_READ &&
		    item.func <= i2cbb_pkg::CMD_REG_WRITE) begin
			cmd  = item.func;
			addr = item.target_addr;
			rg   = item.reg_addr;
			bl   = item.length;
			if ((item.func == i2cbb_pkg::CMD_READ || item.func == i2cbb_pkg::CMD_REG_READ) &&
			    item.length == 8'd0) begin
				bl = 8'd1;
			end
			ph = i2cbb_pkg::PH_START1;
			s  = '0;
		end

		wpos = i2cbb_pkg::slot_split(s);
		rpos = i2cbb_pkg::slot_split(s - 5'd1);

		case (ph)
			i2cbb_pkg::PH_START1, i2cbb_pkg::PH_START2: begin
				case (s)
					5'd0: sda_n = 1'b1;
					5'd1: scl_n = 1'b1;
					5'd2: sda_n = 1'b0;
					default: begin
						scl_n = 1'b0;
						last  = 1'b1;
					end
				endcase
				nxt = (ph == i2cbb_pkg::PH_START1) ? i2cbb_pkg::PH_ADDR1 : i2cbb_pkg::PH_ADDR2;
			end
			i2cbb_pkg::PH_ADDR1, i2cbb_pkg::PH_ADDR2, i2cbb_pkg::PH_REG,
			i2cbb_pkg::PH_WRITE: begin
				if (s == 5'd0) begin
					case (ph)
						i2cbb_pkg::PH_ADDR1:
							sb = {addr, (cmd == i2cbb_pkg::CMD_READ)};
						i2cbb_pkg::PH_ADDR2:
							sb = {addr, 1'b1};
						i2cbb_pkg::PH_REG:
							sb = rg;
						default: begin
							sb           = item.tx_data;
							res.tx_taken = 1'b1;
						end
					endcase
				end
				if (s < i2cbb_pkg::SLOT_BITS_END) begin
					case (wpos.sub)
						2'd0:    sda_n = sb[~wpos.bit_idx];
						2'd1:    scl_n = 1'b1;
						default: scl_n = 1'b0;
					endcase
				end else if (s == i2cbb_pkg::SLOT_BITS_END) begin
					sda_n = 1'b1;
				end else if (s == i2cbb_pkg::SLOT_ACK_SCL) begin
					scl_n = 1'b1;
				end else if (s == i2cbb_pkg::SLOT_ACK_SMP) begin
					ack = item.sda_level;
				end else begin
					scl_n = 1'b0;
					last  = 1'b1;
				end
				case (ph)
					i2cbb_pkg::PH_ADDR1: begin
						if (ack)
							nxt = i2cbb_pkg::PH_STOP_NACK;
						else if (cmd == i2cbb_pkg::CMD_READ)
							nxt = i2cbb_pkg::PH_READ;
						else if (cmd == i2cbb_pkg::CMD_WRITE)
							nxt = (bl == 8'd0) ? i2cbb_pkg::PH_STOP : i2cbb_pkg::PH_WRITE;
						else
							nxt = i2cbb_pkg::PH_REG;
					end
					i2cbb_pkg::PH_ADDR2:
						nxt = ack ? i2cbb_pkg::PH_STOP_NACK : i2cbb_pkg::PH_READ;
					i2cbb_pkg::PH_REG: begin
						if (cmd == i2cbb_pkg::CMD_REG_READ)
							nxt = i2cbb_pkg::PH_START2;
						else
							nxt = (bl == 8'd0) ? i2cbb_pkg::PH_STOP : i2cbb_pkg::PH_WRITE;
					end
					default: begin
						if (last) begin
							bl  = bl - 8'd1;
							nxt = (bl == 8'd0) ? i2cbb_pkg::PH_STOP : i2cbb_pkg::PH_WRITE;
						end
					end
				endcase
			end
			i2cbb_pkg::PH_READ: begin
				if (s == 5'd0) begin
					sda_n = 1'b1;
					sb    = '0;
				end else if (s <= i2cbb_pkg::SLOT_BITS_END) begin
					case (rpos.sub)
						2'd0:    scl_n = 1'b1;
						2'd1:    sb    = {sb[6:0], item.sda_level};
						default: scl_n = 1'b0;
					endcase
				end else if (s == i2cbb_pkg::SLOT_ACK_SCL) begin
					// ACK all but the last byte
					sda_n = (bl > 8'd1) ? 1'b0 : 1'b1;
				end else if (s == i2cbb_pkg::SLOT_ACK_SMP) begin
					scl_n = 1'b1;
				end else begin
					scl_n        = 1'b0;
					last         = 1'b1;
					res.rx_valid = 1'b1;
					res.rx_data  = sb;
					bl           = bl - 8'd1;
					nxt = (bl == 8'd0) ? i2cbb_pkg::PH_STOP : i2cbb_pkg::PH_READ;
				end
			end
			i2cbb_pkg::PH_STOP, i2cbb_pkg::PH_STOP_NACK: begin
				case (s)
					5'd0: sda_n = 1'b0;
					5'd1: scl_n = 1'b1;
					default: begin
						sda_n        = 1'b1;
						last         = 1'b1;
						res.done_res = 1'b1;
						res.status   = (ph == i2cbb_pkg::PH_STOP_NACK);
					end
				endcase
				nxt = i2cbb_pkg::PH_IDLE;
			end
			default: begin
				ph = i2cbb_pkg::PH_IDLE;
				s  = '0;
			end
		endcase

		if (ph != i2cbb_pkg::PH_IDLE) begin
			if (last) begin
				ph = nxt;
				s  = '0;
			end else begin
				s = s + 5'd1;
			end
		end

		res.scl      = scl_n;
		res.sda      = sda_n;
		res.busy_res = (ph != i2cbb_pkg::PH_IDLE);
	end

endmodule

// ----- hdl/i2c_bitbang_master.sv -----
// An accepted word is held in the input register, then steps the sequencer into
// the output register. Throughput: one word per cycle unless a stalled result
// word holds the flow; the sequencer advances one bus slot per word.
// Reset (arst_n low, asynchronous): sequencer idle with its SCL and SDA state
// high, both word registers empty; the result word itself is not reset.
// ----------------------------------------------------------------------------
// i2c_bitbang_master
// I2C master sequencing one pin slot per input word: start, address, register,
// data and stop slots, with address NACK detection and read ACK/NACK.
// ----------------------------------------------------------------------------
module i2c_bitbang_master (
	input  logic       clk,
	input  logic       arst_n,
	// input words
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] func,
	input  logic [6:0] target_addr,
	input  logic [7:0] reg_addr,
	input  logic [7:0] length,
	input  logic [7:0] tx_data,
	input  logic       sda_level,
	// result words
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl,
	output logic       sda,
	output logic [7:0] rx_data,
	output logic       rx_valid,
	output logic       tx_taken,
	output logic       done_res,
	output logic       status,
	output logic       busy_res
);

	// stage 1: registered input word
	logic               valid_s1;
	i2cbb_pkg::item_t   item_s1;
	// stage 2: registered result word
	logic               valid_s2;
	i2cbb_pkg::result_t res_s2;
	i2cbb_pkg::result_t res_step;

	logic advance;   // stage 1 word steps the sequencer this cycle
	logic take_in;

	// the result register frees up when it is empty or being drained
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign take_in  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take_in | (valid_s1 & ~advance);
			valid_s2 <= advance | (valid_s2 & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{func: func, target_addr: target_addr, reg_addr: reg_addr,
			             length: length, tx_data: tx_data, sda_level: sda_level};
		end
		if (advance) begin
			res_s2 <= res_step;
		end
	end

	// bus state only moves when a word is committed to the result register
	i2cbb_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.res     (res_step)
	);

	assign out_valid = valid_s2;
	assign scl       = res_s2.scl;
	assign sda       = res_s2.sda;
	assign rx_data   = res_s2.rx_data;
	assign rx_valid  = res_s2.rx_valid;
	assign tx_taken  = res_s2.tx_taken;
	assign done_res  = res_s2.done_res;
	assign status    = res_s2.status;
	assign busy_res  = res_s2.busy_res;

endmodule

// ----- hdl/i2cbb_checker.sv -----
// ----------------------------------------------------------------------------
// i2cbb_checker
// Port-level checks on the I2C master's result words.
// ----------------------------------------------------------------------------
module i2cbb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl,
	input logic       sda,
	input logic       rx_valid,
	input logic       tx_taken,
	input logic       done_res,
	input logic       status,
	input logic       busy_res
);

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// a stop ends with both lines released and the bus free
	a_done_bus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> scl && sda && !busy_res)
		else $error("stop slot without released lines or still busy");

	// status is only reported with done
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> done_res)
		else $error("status without done");

	// receive, transmit and stop slots never coincide
	a_slot_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(rx_valid && tx_taken) && !(rx_valid && done_res) &&
		              !(tx_taken && done_res))
		else $error("conflicting slot flags");

endmodule

bind i2c_bitbang_master i2cbb_checker u_i2cbb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.scl       (scl),
	.sda       (sda),
	.rx_valid  (rx_valid),
	.tx_taken  (tx_taken),
	.done_res  (done_res),
	.status    (status),
	.busy_res  (busy_res)
);
